// File: hw/rtl/hpr_pkg.sv
// Shared types, sizes and status codes for the handle pool recycler.
`timescale 1ns / 1ps

package hpr_pkg;

  // Pool geometry
  localparam int SLOTS       = 16;
  localparam int HANDLE_BITS = 16;

  // Derived widths
  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int HW_W    = $clog2(SLOTS + 1);
  localparam int STORE_W = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;

  // Result status codes
  localparam logic [1:0] ST_TAKEN   = 2'd0;
  localparam logic [1:0] ST_MISS    = 2'd1;
  localparam logic [1:0] ST_STORED  = 2'd2;
  localparam logic [1:0] ST_DROPPED = 2'd3;

  // Request mode codes
  localparam logic MODE_ACQUIRE = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [15:0] handle_in;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] handle_out;
    logic [3:0]  slot_index;
  } out_rsp_t;

  // Slot decision for the current request
  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] idx;
  } dec_t;

endpackage

// File: hw/rtl/hpr_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module hpr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write on we, capture read data on re
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/hpr_slot_track.sv
// Slot occupancy flags, high-water count and the lowest-slot search.
`timescale 1ns / 1ps

module hpr_slot_track (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          take,
  input  logic          mode,
  output hpr_pkg::dec_t dec
);
  import hpr_pkg::*;

  logic [SLOTS-1:0] full_r, full_nxt;
  logic [HW_W-1:0]  hw_r, hw_nxt;

  logic             full_hit;
  logic [IDX_W-1:0] full_idx;
  logic             empty_hit;
  logic [IDX_W-1:0] empty_idx;
  logic [HW_W+IDX_W-1:0] idx_ext;

  // Find lowest full and lowest empty slot (slots at or above the mark are empty)
  always_comb begin
    full_hit  = 1'b0;
    full_idx  = '0;
    empty_hit = 1'b0;
    empty_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (full_r[i]) begin
        full_hit = 1'b1;
        full_idx = IDX_W'(i);
      end else begin
        empty_hit = 1'b1;
        empty_idx = IDX_W'(i);
      end
    end
  end

  // Decide the outcome of the current request
  always_comb begin
    dec = '0;
    if (mode == MODE_ACQUIRE) begin
      dec.status = full_hit ? ST_TAKEN : ST_MISS;
      dec.idx    = full_hit ? full_idx : '0;
    end else begin
      dec.status = empty_hit ? ST_STORED : ST_DROPPED;
      dec.idx    = empty_hit ? empty_idx : '0;
    end
  end

  assign idx_ext = {{HW_W{1'b0}}, dec.idx};

  // Update flags and grow the mark when a new slot comes into use
  always_comb begin
    full_nxt = full_r;
    hw_nxt   = hw_r;
    if (take) begin
      if (dec.status == ST_TAKEN) begin
        full_nxt[dec.idx] = 1'b0;
      end else if (dec.status == ST_STORED) begin
        full_nxt[dec.idx] = 1'b1;
        if (idx_ext == {{IDX_W{1'b0}}, hw_r}) begin
          hw_nxt = hw_r + HW_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= '0;
      hw_r   <= '0;
    end else begin
      full_r <= full_nxt;
      hw_r   <= hw_nxt;
    end
  end

endmodule

// File: hw/rtl/handle_pool_recycler_core.sv
// Top level of the handle pool recycler: request handshake, handle RAM, result register.
`timescale 1ns / 1ps

// Handle pool recycler. In the accept cycle the occupancy flags pick the
// lowest full (acquire) or lowest empty (release) slot and the handle RAM is
// read or written at that slot; the request then moves to the read state,
// where the registered RAM read data is loaded into the result register once
// that register is free. New requests are held off until the result is loaded,
// so no new request is taken while one is in the read state. A finished result
// may wait in the output register while the next request is accepted. Handles
// are kept in a RAM whose contents are undefined until written; a slot is only
// ever read while it is full, so no clearing pass is needed after reset.
module handle_pool_recycler_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  hpr_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output hpr_pkg::out_rsp_t out_data
);
  import hpr_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state_r, state_nxt;
  logic in_take;
  logic load;
  dec_t dec;
  dec_t pend_r;
  logic ram_we, ram_re;
  logic [STORE_W-1:0] ram_rdata;
  logic [STORE_W+15:0] hout_ext;
  logic [IDX_W+3:0]    idx_ext;
  logic     out_valid_r, out_valid_nxt;
  out_rsp_t out_r, out_nxt;

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;

  hpr_slot_track u_track (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (in_take),
    .mode  (in_data.mode),
    .dec   (dec)
  );

  // Read on an acquire hit, write on a stored release
  assign ram_re = in_take && (dec.status == ST_TAKEN);
  assign ram_we = in_take && (dec.status == ST_STORED);

  hpr_ram #(
    .WIDTH (STORE_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (dec.idx),
    .wdata (in_data.handle_in[STORE_W-1:0]),
    .rdata (ram_rdata)
  );

  // Hold the decision for the result cycle
  always_ff @(posedge clk) begin
    if (in_take) begin
      pend_r <= dec;
    end
  end

  // Load the result register once it is free
  assign load = (state_r == S_READ) && (!out_valid_r || !out_stall);

  assign hout_ext = {16'b0, ram_rdata};
  assign idx_ext  = {4'b0, pend_r.idx};

  always_comb begin
    out_nxt            = out_r;
    out_valid_nxt      = out_valid_r && out_stall;
    state_nxt          = state_r;
    if (in_take) begin
      state_nxt = S_READ;
    end
    if (load) begin
      out_nxt.status     = pend_r.status;
      out_nxt.handle_out = (pend_r.status == ST_TAKEN) ? hout_ext[15:0] : 16'd0;
      out_nxt.slot_index = idx_ext[3:0];
      out_valid_nxt      = 1'b1;
      state_nxt          = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
